// File: rtl/core/multichannel_pulse_width_decoder_core_assert.svh
// Assertion macros used by the pulse-width decoder top level.
`ifndef MULTICHANNEL_PULSE_WIDTH_DECODER_CORE_ASSERT_SVH
`define MULTICHANNEL_PULSE_WIDTH_DECODER_CORE_ASSERT_SVH

// Condition that must hold at every clock edge outside reset.
`define PWDEC_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

// Same-cycle implication outside reset.
`define PWDEC_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/pwdec_pkg.sv
// Shared constants and types of the pulse-width decoder.
`default_nettype none
package pwdec_pkg;

    localparam int NUM_CHANNELS = 8;
    localparam int IDX_W        = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int CH_W         = 3;
    localparam int TS_W         = 16;
    localparam int VAL_W        = 16;
    localparam int CNT_W        = 16;
    localparam int TRIM_W       = 11;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;

    localparam logic [VAL_W-1:0]        BASE_THROTTLE   = 16'd2000;
    localparam logic [VAL_W-1:0]        BASE_OTHER      = 16'd3000;
    localparam logic signed [TRIM_W-1:0] TRIM_RESET     = 11'sd77;
    localparam logic [CH_W-1:0]         THROTTLE_RESET  = 3'd2;
    localparam logic [TS_W-1:0]         PERIOD_RESET    = 16'hFFFF;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TRIM_OFFSET      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THROTTLE_CHANNEL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TIMER_PERIOD     = 2'd2;

    // result queue
    localparam int OQ_DEPTH = 3;
    localparam int OQ_PTR_W = 2;
    localparam int OQ_CNT_W = 2;

    typedef struct packed {
        logic [TS_W-1:0]  stamp;
        logic             level;
        logic [VAL_W-1:0] value;
        logic [CNT_W-1:0] count;
    } t_chan_state;

    typedef struct packed {
        logic [CH_W-1:0]  channel;
        logic             done;
        logic [VAL_W-1:0] value;
        logic [CNT_W-1:0] count;
    } t_result;

endpackage
`default_nettype wire

// File: rtl/core/pwdec_state_ram.sv
// Per-channel state memory, registered read, valid bit per entry.
`default_nettype none
module pwdec_state_ram
    import pwdec_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [IDX_W-1:0]  i_rd_idx,
    output t_chan_state            o_rd_data,
    input  wire logic              i_wr_en,
    input  wire logic [IDX_W-1:0]  i_wr_idx,
    input  wire t_chan_state       i_wr_data
);

    t_chan_state               r_mem [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0]   r_vld;
    t_chan_state               r_rd_data;
    logic                      r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_idx] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= r_vld[i_rd_idx];
            if (i_wr_en) begin
                r_vld[i_wr_idx] <= 1'b1;
            end
        end
    end

    // never-written entry reads as all zero
    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule
`default_nettype wire

// File: rtl/core/pwdec_out_queue.sv
// Three-entry result queue in front of the output channel.
`default_nettype none
module pwdec_out_queue
    import pwdec_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_push,
    input  wire t_result             i_data,
    input  wire logic                i_pop,
    output logic                     o_valid,
    output t_result                  o_data,
    output logic [OQ_CNT_W-1:0]      o_count
);

    localparam logic [OQ_PTR_W-1:0] LAST_PTR = OQ_PTR_W'(OQ_DEPTH - 1);

    t_result               r_buf [OQ_DEPTH];
    logic [OQ_PTR_W-1:0]   r_wr_ptr;
    logic [OQ_PTR_W-1:0]   r_rd_ptr;
    logic [OQ_CNT_W-1:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    assign o_valid = (r_cnt != '0);
    assign o_data  = r_buf[r_rd_ptr];
    assign o_count = r_cnt;

endmodule
`default_nettype wire

// File: rtl/core/multichannel_pulse_width_decoder_core.sv
// Top level of the multichannel RC pulse-width decoder.
//
// Input channel (i_valid / o_stall): one pin-change event per transfer:
// channel number, 16-bit timer stamp and the new pin level.
// Output channel (o_valid / i_stall): one result per event, in order:
// channel, pulse-done flag, channel's decoded value, event count.
// Config port: i_cfg_we with i_cfg_idx selects trim offset (0),
// throttle channel (1) or timer period (2); other indexes are ignored.
// Path: a result passes the stage-1 registers and is then written into the
// result queue, whose head drives the output.
// Throughput: one event per cycle while o_stall is low, set by the single
// read-modify-write pass over the channel state memory (read at accept, write
// in the next cycle, the just-written entry forwarded to a back-to-back event).
// Reset: config registers return to their defaults, all channel state
// reads as zero through per-entry valid bits; no clearing pass is needed.
// Stall: results collect in a three-entry queue; o_stall rises once the
// queue plus the event in flight could overflow it, and drops as it drains.
`default_nettype none
`include "multichannel_pulse_width_decoder_core_assert.svh"
module multichannel_pulse_width_decoder_core
    import pwdec_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    // event input
    input  wire logic                    i_valid,
    output logic                         o_stall,
    input  wire logic [CH_W-1:0]         i_channel,
    input  wire logic [TS_W-1:0]         i_timestamp,
    input  wire logic                    i_level,
    // result output
    output logic                         o_valid,
    input  wire logic                    i_stall,
    output logic [CH_W-1:0]              o_out_channel,
    output logic                         o_pulse_done,
    output logic signed [VAL_W-1:0]      o_pulse_value,
    output logic [CNT_W-1:0]             o_event_count,
    // configuration writes
    input  wire logic                    i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0]   i_cfg_data
);

    // ---------------- configuration registers ----------------
    logic signed [TRIM_W-1:0] r_trim;
    logic [CH_W-1:0]          r_throttle;
    logic [TS_W-1:0]          r_period;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trim     <= TRIM_RESET;
            r_throttle <= THROTTLE_RESET;
            r_period   <= PERIOD_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_TRIM_OFFSET:      r_trim     <= i_cfg_data[TRIM_W-1:0];
                REG_THROTTLE_CHANNEL: r_throttle <= i_cfg_data[CH_W-1:0];
                REG_TIMER_PERIOD:     r_period   <= i_cfg_data[TS_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- stage 0: accept, issue state read ----------------
    logic               w_in_xfer;
    logic [OQ_CNT_W-1:0] w_q_cnt;
    logic               r_s1_vld;

    // stall on queue occupancy and the event in stage 1, independent of i_valid
    assign o_stall   = (w_q_cnt == OQ_CNT_W'(OQ_DEPTH)) ||
                       ((w_q_cnt == OQ_CNT_W'(OQ_DEPTH - 1)) && r_s1_vld);
    assign w_in_xfer = i_valid && !o_stall;

    logic [IDX_W-1:0] w_rd_idx;
    assign w_rd_idx = IDX_W'(i_channel);

    // ---------------- stage 1: modify, write back ----------------
    logic [CH_W-1:0]  r_s1_ch;
    logic [TS_W-1:0]  r_s1_ts;
    logic             r_s1_lvl;
    logic             r_s1_in_range;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= w_in_xfer;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_s1_ch       <= i_channel;
            r_s1_ts       <= i_timestamp;
            r_s1_lvl      <= i_level;
            r_s1_in_range <= (32'(i_channel) < NUM_CHANNELS);
        end
    end

    logic [IDX_W-1:0] w_s1_idx;
    assign w_s1_idx = IDX_W'(r_s1_ch);

    t_chan_state w_rd_data;
    t_chan_state w_cur;
    t_chan_state w_wr_data;
    logic        w_wr_en;

    // last write, kept to cover the entry the memory read just missed
    logic             r_fwd_vld;
    logic [IDX_W-1:0] r_fwd_idx;
    t_chan_state      r_fwd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_vld <= 1'b0;
        end else begin
            r_fwd_vld <= w_wr_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_fwd_idx  <= w_s1_idx;
            r_fwd_data <= w_wr_data;
        end
    end

    assign w_cur = (r_fwd_vld && (r_fwd_idx == w_s1_idx)) ? r_fwd_data : w_rd_data;

    // falling edge closes a pulse
    logic             w_done;
    logic [TS_W-1:0]  w_delta;
    logic [VAL_W-1:0] w_base;
    logic [VAL_W-1:0] w_trim_ext;
    logic [VAL_W-1:0] w_new_value;
    logic [CNT_W-1:0] w_new_count;

    assign w_done      = !r_s1_lvl && w_cur.level;
    // timer wrapped: distance taken modulo the configured period
    assign w_delta     = (r_s1_ts >= w_cur.stamp) ? (r_s1_ts - w_cur.stamp)
                                                  : (r_period - (w_cur.stamp - r_s1_ts));
    assign w_base      = (r_s1_ch == r_throttle) ? BASE_THROTTLE : BASE_OTHER;
    assign w_trim_ext  = {{(VAL_W-TRIM_W){r_trim[TRIM_W-1]}}, r_trim};
    assign w_new_value = w_delta - w_base + w_trim_ext;
    assign w_new_count = w_cur.count + 1'b1;

    always_comb begin
        w_wr_data.stamp = w_done ? w_cur.stamp : r_s1_ts;
        w_wr_data.level = r_s1_lvl;
        w_wr_data.value = w_done ? w_new_value : w_cur.value;
        w_wr_data.count = w_new_count;
    end

    // channels beyond the table leave state alone
    assign w_wr_en = r_s1_vld && r_s1_in_range;

    pwdec_state_ram u_state_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_idx  (w_rd_idx),
        .o_rd_data (w_rd_data),
        .i_wr_en   (w_wr_en),
        .i_wr_idx  (w_s1_idx),
        .i_wr_data (w_wr_data)
    );

    // ---------------- result queue ----------------
    t_result w_res;
    t_result w_q_data;
    logic    w_q_valid;
    logic    w_out_xfer;

    always_comb begin
        w_res.channel = r_s1_ch;
        w_res.done    = r_s1_in_range && w_done;
        w_res.value   = r_s1_in_range ? w_wr_data.value : '0;
        w_res.count   = r_s1_in_range ? w_wr_data.count : '0;
    end

    assign w_out_xfer = w_q_valid && !i_stall;

    pwdec_out_queue u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_s1_vld),
        .i_data  (w_res),
        .i_pop   (w_out_xfer),
        .o_valid (w_q_valid),
        .o_data  (w_q_data),
        .o_count (w_q_cnt)
    );

    assign o_valid       = w_q_valid;
    assign o_out_channel = w_q_data.channel;
    assign o_pulse_done  = w_q_data.done;
    assign o_pulse_value = w_q_data.value;
    assign o_event_count = w_q_data.count;

    // ---------------- checks ----------------
    `PWDEC_ASSERT_IMPL(a_queue_room, r_s1_vld, w_q_cnt != OQ_CNT_W'(OQ_DEPTH), "queue full at push")
    `PWDEC_ASSERT_IMPL(a_fwd_hit, r_s1_vld && $past(w_wr_en) && (w_s1_idx == $past(w_s1_idx)), w_cur == $past(w_wr_data), "stale channel state")
    `PWDEC_ASSERT_IMPL(a_range_quiet, r_s1_vld && !r_s1_in_range, !w_wr_en && !w_res.done, "out-of-range write")

endmodule
`default_nettype wire
